// ===== sv/drdf_pkg.sv =====
// Shared types, constants and register codes for the detection row decoder.
package drdf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int VALUE_W     = 32;
  localparam int CONF_W      = 17;
  localparam int EDGE_W      = 16;
  localparam int PROD_W      = 48;
  localparam int MAG_W       = PROD_W - (FRAC_BITS + 1);
  localparam int CONF_SHIFT  = 2 * FRAC_BITS - 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam logic [CONF_W-1:0] CONF_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_THRESHOLD = 3'd0,
    REG_NUM_CLASSES    = 3'd1,
    REG_MODEL_WIDTH    = 3'd2,
    REG_MODEL_HEIGHT   = 3'd3,
    REG_FRAME_WIDTH    = 3'd4,
    REG_FRAME_HEIGHT   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONF,
    BK_MUL,
    BK_ABS,
    BK_DIV,
    BK_SAT,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [16:0] conf_threshold;
    logic [7:0]  num_classes;
    logic [12:0] model_width;
    logic [12:0] model_height;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] center_x;
    logic signed [VALUE_W-1:0] center_y;
    logic signed [VALUE_W-1:0] box_width;
    logic signed [VALUE_W-1:0] box_height;
    logic signed [VALUE_W-1:0] objectness;
    logic signed [VALUE_W-1:0] best_score;
    logic [7:0]                best_class;
    logic [15:0]               row_index;
  } job_t;

  typedef struct packed {
    logic [7:0]               class_idx;
    logic [CONF_W-1:0]        confidence;
    logic signed [EDGE_W-1:0] box_left;
    logic signed [EDGE_W-1:0] box_top;
    logic signed [EDGE_W-1:0] box_right;
    logic signed [EDGE_W-1:0] box_bottom;
    logic [15:0]              row_index;
  } result_t;

endpackage

// ===== sv/drdf_if.sv =====
// Channel interfaces: tensor values in, detections out, register writes.
interface drdf_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   value;
  logic                 frame_start;
  modport source (output valid, value, frame_start, input ready);
  modport sink (input valid, value, frame_start, output ready);
endinterface

interface drdf_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          class_idx;
  logic [16:0]         confidence;
  logic signed [15:0]  box_left;
  logic signed [15:0]  box_top;
  logic signed [15:0]  box_right;
  logic signed [15:0]  box_bottom;
  logic [15:0]         row_index;
  modport source (output valid, class_idx, confidence, box_left, box_top, box_right,
                  box_bottom, row_index, input ready);
  modport sink (input valid, class_idx, confidence, box_left, box_top, box_right,
                box_bottom, row_index, output ready);
endinterface

interface drdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/drdf_front.sv =====
// Front end: row position tracking, box field capture and class argmax.
module drdf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_value,
  input  logic                        in_frame_start,
  input  logic [7:0]                  num_classes,
  input  logic                        queue_full,
  output logic                        push,
  output drdf_pkg::job_t              push_job
);

  logic [8:0]  element_position;
  logic [15:0] row_counter;
  drdf_pkg::job_t row, row_next;
  logic [8:0]  pos;
  logic [15:0] rc;
  logic [8:0]  last;
  logic        at_end;
  logic        take;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;
  assign last     = {1'b0, num_classes} + 9'd4;
  assign pos      = in_frame_start ? 9'd0 : element_position;
  assign rc       = in_frame_start ? 16'd0 : row_counter;
  assign at_end   = pos >= last;

  always_comb begin
    row_next = row;
    row_next.row_index = rc;
    if (pos == 9'd0) begin
      row_next.best_score = '0;
      row_next.best_class = '0;
    end
    case (pos)
      9'd0: row_next.center_x   = in_value;
      9'd1: row_next.center_y   = in_value;
      9'd2: row_next.box_width  = in_value;
      9'd3: row_next.box_height = in_value;
      9'd4: row_next.objectness = in_value;
      default: begin
        if (in_value > row_next.best_score) begin
          row_next.best_score = in_value;
          row_next.best_class = 8'(pos - 9'd5);
        end
      end
    endcase
  end

  assign push     = take && at_end;
  assign push_job = row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_position <= '0;
      row_counter      <= '0;
      row              <= '0;
    end else if (take) begin
      row <= row_next;
      if (at_end) begin
        element_position <= '0;
        row_counter      <= (rc != 16'hFFFF) ? rc + 16'd1 : rc;
      end else begin
        element_position <= pos + 9'd1;
        row_counter      <= rc;
      end
    end
  end

endmodule

// ===== sv/drdf_queue.sv =====
// Short queue of finished rows between the front and back ends.
module drdf_queue #(
  parameter int DEPTH = drdf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  drdf_pkg::job_t push_job,
  input  logic           pop,
  output drdf_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  drdf_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/drdf_back.sv =====
// Back end: confidence filter, box scaling with a shared serial divider, output register.
module drdf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  drdf_pkg::cfg_t       cfg,
  input  logic                 queue_empty,
  input  drdf_pkg::job_t       pop_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output drdf_pkg::result_t    result
);

  localparam int MAG_W = drdf_pkg::MAG_W;
  localparam int CNT_W = $clog2(MAG_W + 1);

  drdf_pkg::back_state_t state, state_next;
  drdf_pkg::job_t job;
  drdf_pkg::result_t res;
  logic [1:0]                 edge_idx;
  logic signed [47:0]         prod;
  logic [MAG_W-1:0]           dividend, quo;
  logic [13:0]                rem;
  logic                       neg;
  logic [CNT_W-1:0]           cnt;
  logic                       pass;

  logic signed [63:0]         obj_scaled, thr_scaled;
  logic [61:0]                conf_prod, conf_full;
  logic [16:0]                conf_sat;
  logic                       obj_ok;
  logic signed [31:0]         sel_c, sel_s;
  logic                       sel_plus;
  logic [13:0]                sel_mul;
  logic [12:0]                sel_div, div_raw;
  logic signed [33:0]         c_dbl;
  logic signed [33:0]         num;
  logic signed [48:0]         prod_full;
  logic [47:0]                mag;
  logic [13:0]                rem_sh;
  logic                       q_bit;
  logic signed [15:0]         edge_val;

  assign obj_scaled = 64'(job.objectness) <<< 16;
  assign thr_scaled = $signed({47'd0, cfg.conf_threshold}) <<< drdf_pkg::FRAC_BITS;
  assign obj_ok     = obj_scaled >= thr_scaled;
  assign conf_prod  = {31'd0, job.objectness[30:0]} * {31'd0, job.best_score[30:0]};
  assign conf_full  = conf_prod >> drdf_pkg::CONF_SHIFT;
  assign conf_sat   = (conf_full > 62'(drdf_pkg::CONF_ONE)) ? drdf_pkg::CONF_ONE
                                                            : conf_full[16:0];

  always_comb begin
    sel_c    = edge_idx[0] ? job.center_y : job.center_x;
    sel_s    = edge_idx[0] ? job.box_height : job.box_width;
    sel_plus = edge_idx[1];
    sel_mul  = edge_idx[0] ? cfg.frame_height : cfg.frame_width;
    div_raw  = edge_idx[0] ? cfg.model_height : cfg.model_width;
    sel_div  = (div_raw == '0) ? 13'd1 : div_raw;
  end

  assign c_dbl     = {sel_c[31], sel_c, 1'b0};
  assign num       = sel_plus ? (c_dbl + 34'(sel_s)) : (c_dbl - 34'(sel_s));
  assign prod_full = num * $signed({1'b0, sel_mul});
  assign mag       = prod[47] ? 48'(-prod) : 48'(prod);
  assign rem_sh    = {rem[12:0], dividend[MAG_W-1]};
  assign q_bit     = rem_sh >= {1'b0, sel_div};

  always_comb begin
    if (neg) begin
      edge_val = (quo > MAG_W'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, quo}));
    end else begin
      edge_val = (quo > MAG_W'(32767)) ? 16'sd32767 : 16'(quo);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      drdf_pkg::BK_IDLE: if (!queue_empty) state_next = drdf_pkg::BK_CONF;
      drdf_pkg::BK_CONF: state_next = pass ? drdf_pkg::BK_MUL : drdf_pkg::BK_IDLE;
      drdf_pkg::BK_MUL:  state_next = drdf_pkg::BK_ABS;
      drdf_pkg::BK_ABS:  state_next = drdf_pkg::BK_DIV;
      drdf_pkg::BK_DIV:  if (cnt == CNT_W'(MAG_W - 1)) state_next = drdf_pkg::BK_SAT;
      drdf_pkg::BK_SAT:  state_next = (edge_idx == 2'd3) ? drdf_pkg::BK_OUT : drdf_pkg::BK_MUL;
      drdf_pkg::BK_OUT:  if (out_ready) state_next = drdf_pkg::BK_IDLE;
      default:           state_next = drdf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == drdf_pkg::BK_IDLE) && !queue_empty;
    out_valid = state == drdf_pkg::BK_OUT;
    pass      = obj_ok && (conf_sat >= cfg.conf_threshold);
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drdf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      drdf_pkg::BK_IDLE: begin
        job      <= pop_job;
        edge_idx <= '0;
      end
      drdf_pkg::BK_CONF: begin
        res.class_idx  <= job.best_class;
        res.confidence <= conf_sat;
        res.row_index  <= job.row_index;
      end
      drdf_pkg::BK_MUL: prod <= prod_full[47:0];
      drdf_pkg::BK_ABS: begin
        dividend <= MAG_W'(mag >> (drdf_pkg::FRAC_BITS + 1));
        neg      <= prod[47];
        rem      <= '0;
        quo      <= '0;
        cnt      <= '0;
      end
      drdf_pkg::BK_DIV: begin
        rem      <= q_bit ? rem_sh - {1'b0, sel_div} : rem_sh;
        quo      <= {quo[MAG_W-2:0], q_bit};
        dividend <= {dividend[MAG_W-2:0], 1'b0};
        cnt      <= cnt + 1'b1;
      end
      drdf_pkg::BK_SAT: begin
        case (edge_idx)
          2'd0:    res.box_left   <= edge_val;
          2'd1:    res.box_top    <= edge_val;
          2'd2:    res.box_right  <= edge_val;
          default: res.box_bottom <= edge_val;
        endcase
        edge_idx <= edge_idx + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/detection_row_decode_filter.sv =====
// Top level: register file, front end, row queue and back end.
// Throughput: one value per cycle until the row queue fills; each passing row holds the
// back end through the shared serial divider for all four box edges, a dropped row only for BK_IDLE and BK_CONF.
// Reset (rst, synchronous): registers take their defaults, row position, row counter
// and queue clear, the back end returns to idle.
module detection_row_decode_filter #(
  parameter int QUEUE_DEPTH = drdf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  drdf_in_if.sink          din,
  drdf_out_if.source       dout,
  drdf_cfg_if.sink         cfg
);

  drdf_pkg::cfg_t    regs;
  drdf_pkg::job_t    push_job, pop_job;
  drdf_pkg::result_t result;
  logic push, pop, q_full, q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.conf_threshold <= 17'd32768;
      regs.num_classes    <= 8'd80;
      regs.model_width    <= 13'd640;
      regs.model_height   <= 13'd640;
      regs.frame_width    <= 14'd640;
      regs.frame_height   <= 14'd640;
    end else if (cfg.valid) begin
      case (drdf_pkg::reg_idx_t'(cfg.index))
        drdf_pkg::REG_CONF_THRESHOLD: regs.conf_threshold <= cfg.data;
        drdf_pkg::REG_NUM_CLASSES:    regs.num_classes    <= cfg.data[7:0];
        drdf_pkg::REG_MODEL_WIDTH:    regs.model_width    <= cfg.data[12:0];
        drdf_pkg::REG_MODEL_HEIGHT:   regs.model_height   <= cfg.data[12:0];
        drdf_pkg::REG_FRAME_WIDTH:    regs.frame_width    <= cfg.data[13:0];
        drdf_pkg::REG_FRAME_HEIGHT:   regs.frame_height   <= cfg.data[13:0];
        default: ;
      endcase
    end
  end

  drdf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (din.valid),
    .in_ready       (din.ready),
    .in_value       (din.value),
    .in_frame_start (din.frame_start),
    .num_classes    (regs.num_classes),
    .queue_full     (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  drdf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  drdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .queue_empty (q_empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .result      (result)
  );

  assign dout.class_idx  = result.class_idx;
  assign dout.confidence = result.confidence;
  assign dout.box_left   = result.box_left;
  assign dout.box_top    = result.box_top;
  assign dout.box_right  = result.box_right;
  assign dout.box_bottom = result.box_bottom;
  assign dout.row_index  = result.row_index;

endmodule

// ===== tb/detection_row_decode_filter_checker.sv =====
// Checker: tracks register writes, predicts detections per row and compares results.
module detection_row_decode_filter_checker (
  input  logic clk,
  input  logic rst,
  drdf_in_if   din,
  drdf_out_if  dout,
  drdf_cfg_if  cfg,
  output int   failures,
  output int   pending
);

  drdf_pkg::cfg_t      regs;
  logic [8:0]          pos;
  logic [15:0]         row_no;
  logic signed [31:0]  cx, cy, bw, bh, obj, top_score;
  logic [7:0]          top_class;
  drdf_pkg::result_t   detections_due[$];

  assign pending = detections_due.size();

  function automatic logic signed [15:0] scale_edge(input logic signed [31:0] c,
                                                    input logic signed [31:0] size,
                                                    input bit plus,
                                                    input logic [13:0] mul,
                                                    input logic [12:0] divr);
    longint num, den, q;
    num = 2 * longint'(c) + (plus ? longint'(size) : -longint'(size));
    den = longint'(divr == 0 ? 13'd1 : divr) << (drdf_pkg::FRAC_BITS + 1);
    q = (num * longint'(mul)) / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void apply_write(input logic [2:0] idx, input logic [16:0] d);
    case (drdf_pkg::reg_idx_t'(idx))
      drdf_pkg::REG_CONF_THRESHOLD: regs.conf_threshold = d;
      drdf_pkg::REG_NUM_CLASSES:    regs.num_classes    = d[7:0];
      drdf_pkg::REG_MODEL_WIDTH:    regs.model_width    = d[12:0];
      drdf_pkg::REG_MODEL_HEIGHT:   regs.model_height   = d[12:0];
      drdf_pkg::REG_FRAME_WIDTH:    regs.frame_width    = d[13:0];
      drdf_pkg::REG_FRAME_HEIGHT:   regs.frame_height   = d[13:0];
      default: ;
    endcase
  endfunction

  function automatic bit decode_value(input logic signed [31:0] v, input logic fs,
                                      output drdf_pkg::result_t r);
    logic [8:0] last;
    longint     conf;
    bit         hit;
    hit = 1'b0;
    r = '0;
    last = {1'b0, regs.num_classes} + 9'd4;
    if (fs) begin
      pos = '0;
      row_no = '0;
    end
    if (pos == 9'd0) begin
      top_score = '0;
      top_class = '0;
    end
    case (pos)
      9'd0: cx = v;
      9'd1: cy = v;
      9'd2: bw = v;
      9'd3: bh = v;
      9'd4: obj = v;
      default: begin
        if (v > top_score) begin
          top_score = v;
          top_class = 8'(pos - 9'd5);
        end
      end
    endcase
    if (pos >= last) begin
      if (longint'(obj) >= longint'(regs.conf_threshold)) begin
        conf = (longint'(obj) * longint'(top_score)) >> drdf_pkg::CONF_SHIFT;
        if (conf > 65536) conf = 65536;
        if (conf >= longint'(regs.conf_threshold)) begin
          r.class_idx  = top_class;
          r.confidence = conf[16:0];
          r.box_left   = scale_edge(cx, bw, 0, regs.frame_width, regs.model_width);
          r.box_top    = scale_edge(cy, bh, 0, regs.frame_height, regs.model_height);
          r.box_right  = scale_edge(cx, bw, 1, regs.frame_width, regs.model_width);
          r.box_bottom = scale_edge(cy, bh, 1, regs.frame_height, regs.model_height);
          r.row_index  = row_no;
          hit = 1'b1;
        end
      end
      pos = '0;
      if (row_no != 16'hFFFF) row_no = row_no + 16'd1;
    end else begin
      pos = pos + 9'd1;
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    drdf_pkg::result_t want, got;
    if (rst) begin
      regs.conf_threshold <= 17'd32768;
      regs.num_classes    <= 8'd80;
      regs.model_width    <= 13'd640;
      regs.model_height   <= 13'd640;
      regs.frame_width    <= 14'd640;
      regs.frame_height   <= 14'd640;
      pos <= '0;
      row_no <= '0;
      {cx, cy, bw, bh, obj, top_score} <= '0;
      top_class <= '0;
      detections_due.delete();
    end else begin
      if (dout.valid && dout.ready) begin
        got.class_idx  = dout.class_idx;
        got.confidence = dout.confidence;
        got.box_left   = dout.box_left;
        got.box_top    = dout.box_top;
        got.box_right  = dout.box_right;
        got.box_bottom = dout.box_bottom;
        got.row_index  = dout.row_index;
        if (detections_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected detection: row %0d class %0d conf %0d",
                     got.row_index, got.class_idx, got.confidence);
        end else begin
          want = detections_due.pop_front();
          if (got.class_idx !== want.class_idx || got.confidence !== want.confidence ||
              got.box_left !== want.box_left || got.box_top !== want.box_top ||
              got.box_right !== want.box_right || got.box_bottom !== want.box_bottom ||
              got.row_index !== want.row_index) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch: exp row %0d cls %0d conf %0d box %0d %0d %0d %0d",
                       want.row_index, want.class_idx, want.confidence, want.box_left,
                       want.box_top, want.box_right, want.box_bottom);
              $display("          got row %0d cls %0d conf %0d box %0d %0d %0d %0d",
                       got.row_index, got.class_idx, got.confidence, got.box_left,
                       got.box_top, got.box_right, got.box_bottom);
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) apply_write(cfg.index, cfg.data);
      if (din.valid && din.ready)
        if (decode_value(din.value, din.frame_start, want))
          detections_due.insert(detections_due.size(), want);
    end
  end

endmodule

// ===== tb/detection_row_decode_filter_test.sv =====
// Testbench top: clock, reset, register phases, tensor stimulus and verdict.
module detection_row_decode_filter_test;

  logic clk = 0;
  logic rst = 1;
  int   failures, pending;
  bit   quiet = 0;
  int   out_hold = 0;
  int   cur_nc = 80;
  int   cur_thr = 32768;
  logic signed [31:0] prev_score = 0;

  drdf_in_if  din_ch ();
  drdf_out_if dout_ch ();
  drdf_cfg_if cfg_ch ();

  detection_row_decode_filter DUT (
    .clk (clk),
    .rst (rst),
    .din (din_ch),
    .dout(dout_ch),
    .cfg (cfg_ch)
  );

  detection_row_decode_filter_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .din     (din_ch),
    .dout    (dout_ch),
    .cfg     (cfg_ch),
    .failures(failures),
    .pending (pending)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) quiet <= !quiet;
  end

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      dout_ch.ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 3) != 0) begin
      dout_ch.ready <= 1'b1;
    end else begin
      out_hold <= pick_gap() - 1;
      dout_ch.ready <= 1'b0;
    end
  end

  task automatic push_value(input logic signed [31:0] v, input logic fs);
    bit ok;
    int gap;
    din_ch.valid <= 1'b1;
    din_ch.value <= v;
    din_ch.frame_start <= fs;
    do begin
      @(negedge clk);
      ok = din_ch.ready;
      @(posedge clk);
    end while (!ok);
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input drdf_pkg::reg_idx_t idx, input logic [16:0] d);
    bit ok;
    din_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do begin
      @(negedge clk);
      ok = cfg_ch.ready;
      @(posedge clk);
    end while (!ok);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == drdf_pkg::REG_NUM_CLASSES) cur_nc = int'(d[7:0]);
    if (idx == drdf_pkg::REG_CONF_THRESHOLD) cur_thr = int'(d);
  endtask

  task automatic drain();
    din_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_all(input logic [16:0] thr, input logic [7:0] nc,
                           input logic [12:0] mw, input logic [12:0] mh,
                           input logic [13:0] fw, input logic [13:0] fh);
    write_reg(drdf_pkg::REG_CONF_THRESHOLD, thr);
    write_reg(drdf_pkg::REG_NUM_CLASSES, {9'd0, nc});
    write_reg(drdf_pkg::REG_MODEL_WIDTH, {4'd0, mw});
    write_reg(drdf_pkg::REG_MODEL_HEIGHT, {4'd0, mh});
    write_reg(drdf_pkg::REG_FRAME_WIDTH, {3'd0, fw});
    write_reg(drdf_pkg::REG_FRAME_HEIGHT, {3'd0, fh});
  endtask

  function automatic logic signed [31:0] any_extreme();
    case ($urandom_range(0, 3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_coord(input int span);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return ($urandom_range(0, span) << 16) | $urandom_range(0, 65535);
    if (r < 9) return $urandom();
    return any_extreme();
  endfunction

  function automatic logic signed [31:0] pick_obj();
    int r, lo;
    r = $urandom_range(0, 9);
    lo = cur_thr > 65536 ? 65536 : cur_thr;
    if (r < 6) return $urandom_range(lo, 65536);
    if (r < 8) return $urandom_range(0, 65536);
    if (r < 9) return $urandom();
    return any_extreme();
  endfunction

  function automatic logic signed [31:0] pick_score();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) prev_score = $urandom_range(0, 65536);
    else if (r == 6) prev_score = 65536;
    else if (r == 8) prev_score = $urandom();
    else if (r == 9) prev_score = -$urandom_range(1, 65536);
    return prev_score;
  endfunction

  task automatic send_row(input int count);
    logic fs;
    logic signed [31:0] v;
    for (int k = 0; k < count; k++) begin
      fs = (k == 0 && $urandom_range(0, 9) == 0) || $urandom_range(0, 59) == 0;
      case (k)
        0, 1: v = pick_coord(4096);
        2, 3: v = pick_coord(600);
        4: v = pick_obj();
        default: v = pick_score();
      endcase
      push_value(v, fs);
    end
  endtask

  task automatic random_phase(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      send_row(cur_nc + 5);
      sent += cur_nc + 5;
    end
    if ($urandom_range(0, 1) == 1) send_row($urandom_range(1, cur_nc + 4));
    drain();
  endtask

  initial begin
    din_ch.valid <= 1'b0;
    din_ch.value <= '0;
    din_ch.frame_start <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= drdf_pkg::REG_CONF_THRESHOLD;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows: tie, saturation, negative objectness
    write_all(17'd32768, 8'd2, 13'd640, 13'd640, 14'd1280, 14'd720);
    push_value(320 << 16, 1'b1); push_value(240 << 16, 1'b0); push_value(100 << 16, 1'b0);
    push_value(50 << 16, 1'b0); push_value(65536, 1'b0); push_value(49152, 1'b0);
    push_value(49152, 1'b0);
    push_value(32'sh7FFFFFFF, 1'b0); push_value(32'sh80000000, 1'b0);
    push_value(32'sh80000000, 1'b0); push_value(32'sh7FFFFFFF, 1'b0);
    push_value(32'sh7FFFFFFF, 1'b0); push_value(0, 1'b0); push_value(32'sh7FFFFFFF, 1'b0);
    push_value(100 << 16, 1'b0); push_value(100 << 16, 1'b0); push_value(10 << 16, 1'b0);
    push_value(10 << 16, 1'b0); push_value(32'sh80000000, 1'b0); push_value(65536, 1'b0);
    push_value(65536, 1'b0);
    drain();

    write_all(17'd0, 8'd0, 13'd0, 13'd0, 14'd16383, 14'd16383);
    random_phase(200);
    write_all(17'd131071, 8'd255, 13'd8191, 13'd8191, 14'd0, 14'd0);
    random_phase(200);
    write_all(17'd65536, 8'd1, 13'd1, 13'd1, 14'd1, 14'd1);
    random_phase(150);
    write_all(17'd1, 8'($urandom_range(1, 8)), 13'd4096, 13'd4096, 14'd8192, 14'd8192);
    random_phase(200);
    repeat (4) begin
      write_all(17'($urandom_range(0, 65536)), 8'($urandom_range(1, 6)),
                13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
      random_phase(200);
    end

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #(12 * 800000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
sv/drdf_pkg.sv
sv/drdf_if.sv
sv/drdf_front.sv
sv/drdf_queue.sv
sv/drdf_back.sv
sv/detection_row_decode_filter.sv
tb/detection_row_decode_filter_checker.sv
tb/detection_row_decode_filter_test.sv
